[hdl/psd_pkg.sv]
// Shared types, widths and register indexes for the small-prime divisibility tester.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package psd_pkg;

   localparam int K_WIDTH          = 64;
   localparam int EXP_WIDTH_MAX    = 32;
   localparam int EXPONENT_BITS_DEF = 32;
   localparam int PRIME_WIDTH      = 15;
   localparam int MONT_BITS        = 16;
   localparam int MUL_W            = 16;
   localparam int NEWTON_STEPS     = 3;
   localparam int CNT_W            = $clog2(K_WIDTH);
   localparam int REQ_DATA_W       = 16;
   localparam int RSP_DATA_W       = 16;
   localparam int CSR_ADDR_W       = 2;
   localparam int CSR_DATA_W       = 64;

   // Register indexes on the configuration port.
   localparam logic [CSR_ADDR_W-1:0] CSR_MULTIPLIER_K = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_EXPONENT_N   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PLUS_SIGN    = 2'd2;

   localparam logic [K_WIDTH-1:0]       K_RESET    = 64'd3;
   localparam logic [EXP_WIDTH_MAX-1:0] N_RESET    = 32'd16;
   localparam logic                     PLUS_RESET = 1'b0;

   localparam logic [MUL_W-1:0] NEWTON_TWO = 16'd2;

   typedef logic [PRIME_WIDTH-1:0] prime_type;

   // One result beat, divides in the lowest bit.
   typedef struct packed {
      prime_type prime;
      logic      divides;
   } result_type;

endpackage

[hdl/proth_small_prime_divisibility.sv]
// Top level of the Proth-number small-prime divisibility tester: stream ports and registers.
// Depends on psd_pkg and psd_core.
`timescale 1ns / 1ps

// Tests whether each odd prime p on the request stream divides k*2^n+1 or k*2^n-1, with k, n
// and the sign set through the register port beforehand. Primes are taken one at a time: a
// new request is taken only once the last result has been written to the output register.
// The walk over n runs on the one shared multiplier, with a Montgomery square, reduce and
// halve step for every exponent bit, after the 64-bit k has been reduced one bit per cycle.
// An even value or one below three skips the walk and is answered as not dividing. A
// finished response sits in an output register, so a stalled response stream holds up
// only the next result.

module proth_small_prime_divisibility
   import psd_pkg::*;
#(
   parameter int EXPONENT_BITS = EXPONENT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [14:0] prime, [15] zero
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] divides, [15:1] tested_prime
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [K_WIDTH-1:0]       k_ff;
   logic [EXPONENT_BITS-1:0] n_ff;
   logic                     plus_ff;
   result_type               result;

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff    <= K_RESET;
         n_ff    <= N_RESET[EXPONENT_BITS-1:0];
         plus_ff <= PLUS_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_MULTIPLIER_K: k_ff    <= csr_wdata[K_WIDTH-1:0];
            CSR_EXPONENT_N:   n_ff    <= csr_wdata[EXPONENT_BITS-1:0];
            CSR_PLUS_SIGN:    plus_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   psd_core #(
      .EXPONENT_BITS (EXPONENT_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .multiplier_k (k_ff),
      .exponent_n   (n_ff),
      .plus_sign    (plus_ff),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_prime     (req_tdata[PRIME_WIDTH-1:0]),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_result   (result)
   );

   assign rsp_tdata = result;

endmodule

[hdl/psd_mul.sv]
// Shared 16 x 16 unsigned multiplier of the tester; every product passes through it.
// Depends on psd_pkg for the operand width.
`timescale 1ns / 1ps

module psd_mul
   import psd_pkg::*;
(
   input  logic [MUL_W-1:0]   a,
   input  logic [MUL_W-1:0]   b,
   output logic [2*MUL_W-1:0] prod
);

   assign prod = (2*MUL_W)'(a) * (2*MUL_W)'(b);

endmodule

[hdl/psd_dblmod.sv]
// Shift-and-subtract step: returns (2*r + bit) mod p for r below p.
// Depends on psd_pkg; used for k mod p and for the Montgomery start value.
`timescale 1ns / 1ps

module psd_dblmod
   import psd_pkg::*;
(
   input  prime_type r,
   input  logic      din,
   input  prime_type p,
   output prime_type r_out
);

   logic [PRIME_WIDTH:0] sum;
   logic [PRIME_WIDTH:0] diff;

   assign sum   = {r, din};
   assign diff  = sum - {1'b0, p};
   assign r_out = (sum >= {1'b0, p}) ? diff[PRIME_WIDTH-1:0] : sum[PRIME_WIDTH-1:0];

endmodule

[hdl/psd_core.sv]
// Sequencer and datapath of the tester: k mod p, Newton inverse, Montgomery walk over n.
// Depends on psd_pkg, psd_mul and psd_dblmod.
`timescale 1ns / 1ps

module psd_core
   import psd_pkg::*;
#(
   parameter int EXPONENT_BITS = EXPONENT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [K_WIDTH-1:0]       multiplier_k,
   input  logic [EXPONENT_BITS-1:0] exponent_n,
   input  logic                     plus_sign,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  prime_type                in_prime,
   output logic                     out_valid,
   input  logic                     out_ready,
   output result_type               out_result
);

   localparam int EXP_IDX_W = $clog2(EXPONENT_BITS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KMOD,
      ST_RMOD,
      ST_NEWTON_Y,
      ST_NEWTON_X,
      ST_SQUARE,
      ST_MULRED,
      ST_REDUCE,
      ST_FIX,
      ST_RESULT
   } state_type;

   state_type            state_ff;
   logic [CNT_W-1:0]     cnt_ff;
   prime_type            p_ff;
   logic                 bad_ff;
   logic                 last_ff;
   prime_type            kmod_ff;
   prime_type            r_ff;
   logic [MUL_W-1:0]     x_ff;
   logic [MUL_W-1:0]     m_ff;
   logic [2*PRIME_WIDTH-1:0] t_ff;
   logic [MUL_W-1:0]     u_ff;
   logic                 out_valid_ff;
   result_type           out_result_ff;

   logic [MUL_W-1:0]     mul_a;
   logic [MUL_W-1:0]     mul_b;
   logic [2*MUL_W-1:0]   prod;
   prime_type            dbl_r;
   logic                 dbl_bit;
   prime_type            dbl_out;
   logic [2*MUL_W-1:0]   red_sum;
   logic [MUL_W-1:0]     u_in;
   logic [MUL_W-1:0]     u_diff;
   prime_type            rc_in;
   logic [PRIME_WIDTH:0] half_sum;
   prime_type            r_in;
   prime_type            neg_in;
   logic                 hit_in;
   logic                 bad_prime;
   logic                 out_free;

   psd_mul u_mul (
      .a    (mul_a),
      .b    (mul_b),
      .prod (prod)
   );

   psd_dblmod u_dblmod (
      .r     (dbl_r),
      .din   (dbl_bit),
      .p     (p_ff),
      .r_out (dbl_out)
   );

   always_comb begin
      unique case (state_ff)
         ST_NEWTON_Y: begin
            mul_a = {1'b0, p_ff};
            mul_b = x_ff;
         end
         ST_NEWTON_X: begin
            mul_a = x_ff;
            mul_b = m_ff;
         end
         ST_SQUARE: begin
            mul_a = {1'b0, r_ff};
            mul_b = {1'b0, r_ff};
         end
         ST_MULRED: begin
            mul_a = t_ff[MUL_W-1:0];
            mul_b = x_ff;
         end
         ST_REDUCE: begin
            mul_a = m_ff;
            mul_b = {1'b0, p_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign dbl_r   = (state_ff == ST_KMOD) ? kmod_ff : r_ff;
   assign dbl_bit = (state_ff == ST_KMOD) ? multiplier_k[cnt_ff] : 1'b0;

   // Montgomery reduction: (t + m*p) / R, which lies below 2p.
   assign red_sum = (2*MUL_W)'(t_ff) + prod;
   assign u_in    = red_sum[2*MUL_W-1:MONT_BITS];

   // Final correction into [0, p), then an optional halving mod p.
   assign u_diff   = u_ff - {1'b0, p_ff};
   assign rc_in    = (u_ff >= {1'b0, p_ff}) ? u_diff[PRIME_WIDTH-1:0]
                                            : u_ff[PRIME_WIDTH-1:0];
   assign half_sum = {1'b0, rc_in} + (rc_in[0] ? {1'b0, p_ff} : '0);
   assign r_in     = exponent_n[cnt_ff[EXP_IDX_W-1:0]] ? half_sum[PRIME_WIDTH:1] : rc_in;

   assign neg_in = (rc_in == '0) ? '0 : (p_ff - rc_in);
   assign hit_in = !bad_ff && ((plus_sign ? neg_in : rc_in) == kmod_ff);

   assign bad_prime = !in_prime[0] || (in_prime < PRIME_WIDTH'(3));
   assign out_free  = !out_valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         bad_ff       <= 1'b0;
         last_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         // In the result state the output register is written below instead.
         if (out_valid_ff && out_ready && (state_ff != ST_RESULT)) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (in_valid) begin
                  p_ff    <= in_prime;
                  kmod_ff <= '0;
                  last_ff <= 1'b0;
                  cnt_ff  <= CNT_W'(K_WIDTH - 1);
                  if (bad_prime) begin
                     bad_ff   <= 1'b1;
                     state_ff <= ST_RESULT;
                  end else begin
                     bad_ff   <= 1'b0;
                     state_ff <= ST_KMOD;
                  end
               end
            end
            ST_KMOD: begin
               kmod_ff <= dbl_out;
               if (cnt_ff == '0) begin
                  r_ff     <= PRIME_WIDTH'(1);
                  cnt_ff   <= CNT_W'(MONT_BITS - 1);
                  state_ff <= ST_RMOD;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ST_RMOD: begin
               // Doubling one sixteen times leaves R mod p, the Montgomery form of one.
               r_ff <= dbl_out;
               if (cnt_ff == '0) begin
                  x_ff     <= {1'b0, p_ff};
                  cnt_ff   <= CNT_W'(NEWTON_STEPS - 1);
                  state_ff <= ST_NEWTON_Y;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ST_NEWTON_Y: begin
               m_ff     <= NEWTON_TWO - prod[MUL_W-1:0];
               state_ff <= ST_NEWTON_X;
            end
            ST_NEWTON_X: begin
               // Each step doubles the correct low bits of 1/p; the last one stores -1/p.
               if (cnt_ff == '0) begin
                  x_ff     <= MUL_W'(0) - prod[MUL_W-1:0];
                  cnt_ff   <= CNT_W'(EXPONENT_BITS - 1);
                  state_ff <= ST_SQUARE;
               end else begin
                  x_ff     <= prod[MUL_W-1:0];
                  cnt_ff   <= cnt_ff - 1'b1;
                  state_ff <= ST_NEWTON_Y;
               end
            end
            ST_SQUARE: begin
               t_ff     <= prod[2*PRIME_WIDTH-1:0];
               state_ff <= ST_MULRED;
            end
            ST_MULRED: begin
               m_ff     <= prod[MUL_W-1:0];
               state_ff <= ST_REDUCE;
            end
            ST_REDUCE: begin
               u_ff     <= u_in;
               state_ff <= last_ff ? ST_RESULT : ST_FIX;
            end
            ST_FIX: begin
               if (cnt_ff == '0) begin
                  // One more reduction takes the residue out of Montgomery form.
                  t_ff     <= (2*PRIME_WIDTH)'(r_in);
                  last_ff  <= 1'b1;
                  state_ff <= ST_MULRED;
               end else begin
                  r_ff     <= r_in;
                  cnt_ff   <= cnt_ff - 1'b1;
                  state_ff <= ST_SQUARE;
               end
            end
            ST_RESULT: begin
               if (out_free) begin
                  out_valid_ff          <= 1'b1;
                  out_result_ff.divides <= hit_in;
                  out_result_ff.prime   <= p_ff;
                  state_ff              <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign in_ready   = (state_ff == ST_IDLE);
   assign out_valid  = out_valid_ff;
   assign out_result = out_result_ff;

endmodule
